// ===== src/cdch_pkg.sv =====
// Package for the concentric disk cosine hemisphere sampler.
// Holds the fixed-point formats, constants and the CORDIC angle table.
// No dependencies.
package cdch_pkg;

  localparam int IN_FRAC_BITS  = 16;
  localparam int OUT_FRAC_BITS = 15;
  localparam int ANG_FRAC      = 30;
  localparam int QUOT_BITS     = ANG_FRAC + 1;
  localparam int ROOT_STEPS    = OUT_FRAC_BITS + 1;
  localparam int ATAN_ENTRIES  = 32;

  localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314856;
  localparam logic [29:0] GAIN_Q30       = 30'd652032874;

  // Angle, rotated point and wedge travel together through the CORDIC.
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic [1:0]         quarter;
  } cdch_cor_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:    val = 30'd843314856;
      5'd1:    val = 30'd497837829;
      5'd2:    val = 30'd263043836;
      5'd3:    val = 30'd133525158;
      5'd4:    val = 30'd67021686;
      5'd5:    val = 30'd33543515;
      5'd6:    val = 30'd16775850;
      5'd7:    val = 30'd8388437;
      5'd8:    val = 30'd4194282;
      5'd9:    val = 30'd2097149;
      5'd10:   val = 30'd1048575;
      5'd11:   val = 30'd524287;
      5'd12:   val = 30'd262143;
      5'd13:   val = 30'd131071;
      5'd14:   val = 30'd65535;
      5'd15:   val = 30'd32767;
      5'd16:   val = 30'd16383;
      5'd17:   val = 30'd8191;
      5'd18:   val = 30'd4095;
      5'd19:   val = 30'd2047;
      5'd20:   val = 30'd1023;
      5'd21:   val = 30'd511;
      5'd22:   val = 30'd255;
      5'd23:   val = 30'd127;
      5'd24:   val = 30'd63;
      5'd25:   val = 30'd31;
      5'd26:   val = 30'd15;
      5'd27:   val = 30'd7;
      5'd28:   val = 30'd3;
      5'd29:   val = 30'd1;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== src/concentric_disk_cosine_hemisphere.sv =====
// Top level of the concentric disk cosine hemisphere sampler.
// Depends on cdch_pkg for formats, constants and the angle table.
//
// Usage: each request on the in_ channel carries two Q0.16 fractions u and v.
// The block maps (2u-1, 2v-1) onto the unit disk with the concentric mapping
// and returns one request on the out_ channel with disk x, disk y (signed
// Q1.15) and the hemisphere height z = sqrt(1 - x^2 - y^2) (Q1.15, 32768 is
// 1.0). The centre point gives (0, 0, 1.0).
// The pipeline has one decode stage, 31 stages of the restoring divider
// (one quotient bit each), one multiply stage, one CORDIC stage per step,
// a rounding stage, a squaring stage and 16 stages of the square root
// (one result bit each). Throughput is one request per cycle while
// out_tready is high. Every stage has its own valid bit and takes new
// data whenever it is empty or its successor moves, so bubbles close up
// while the receiver stalls and no request is lost or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
module concentric_disk_cosine_hemisphere
  import cdch_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_u [15:0], sample_v [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // disk_x [15:0], disk_y [31:16], height_z [47:32]
);

  localparam int S_MUL  = QUOT_BITS + 1;
  localparam int S_RND  = S_MUL + CORDIC_STEPS + 1;
  localparam int S_SQ   = S_RND + 1;
  localparam int NSTAGE = S_SQ + ROOT_STEPS + 1;

  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE-1:0] ld;

  always_comb begin
    ld[NSTAGE-1] = !valid_r[NSTAGE-1] || out_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ld[k] = !valid_r[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ld[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (ld[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_tready  = ld[0];
  assign out_tvalid = valid_r[NSTAGE-1];

  // ---------------- decode: wedge, numerator and denominator ----------------
  logic signed [17:0] a, b, num, den;
  logic [1:0]         qtr_nxt;
  logic [16:0]        nmag, dmag;

  always_comb begin
    a = $signed({1'b0, in_tdata[15:0], 1'b0}) - 18'sd65536;
    b = $signed({1'b0, in_tdata[31:16], 1'b0}) - 18'sd65536;
    if (a > -b) begin
      if (a > b) begin
        num = b;  den = a; qtr_nxt = 2'd0;
      end else begin
        num = -a; den = b; qtr_nxt = 2'd1;
      end
    end else begin
      if (a < b) begin
        num = b;  den = a; qtr_nxt = 2'd2;
      end else begin
        num = -a; den = b; qtr_nxt = 2'd3;
      end
    end
    nmag = num[17] ? 17'(-num) : num[16:0];
    dmag = den[17] ? 17'(-den) : den[16:0];
  end

  // Arrays are indexed by pipeline stage: 0 is decode, 1..31 the divider.
  logic [17:0] rem_r [0:QUOT_BITS];
  logic [16:0] dv_r  [0:QUOT_BITS];
  logic        neg_r [0:QUOT_BITS];
  logic [1:0]  qtr_r [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] quo_r [1:QUOT_BITS];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem_r[0] <= {1'b0, nmag};
      dv_r[0]  <= dmag;
      neg_r[0] <= num[17] ^ den[17];
      qtr_r[0] <= qtr_nxt;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_div
    logic [17:0] rin_nxt;
    logic        bit_nxt;
    logic [QUOT_BITS-1:0] qin;

    always_comb begin
      rin_nxt = (k == 1) ? rem_r[k-1] : {rem_r[k-1][16:0], 1'b0};
      bit_nxt = rin_nxt >= {1'b0, dv_r[k-1]};
      if (k == 1) begin
        qin = '0;
      end else begin
        qin = quo_r[(k == 1) ? 1 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rem_r[k] <= bit_nxt ? rin_nxt - {1'b0, dv_r[k-1]} : rin_nxt;
        quo_r[k] <= {qin[QUOT_BITS-2:0], bit_nxt};
        dv_r[k]  <= dv_r[k-1];
        neg_r[k] <= neg_r[k-1];
        qtr_r[k] <= qtr_r[k-1];
      end
    end
  end

  // ---------------- angle and starting radius ----------------
  localparam logic [QUOT_BITS-1:0] ONE_Q30 = QUOT_BITS'(1) << ANG_FRAC;

  logic [QUOT_BITS-1:0] qclip;
  logic [60:0]          ang_prod, rad_prod;
  logic signed [32:0]   ang_nxt;

  cdch_cor_t cor_r [0:CORDIC_STEPS];

  always_comb begin
    qclip    = (quo_r[QUOT_BITS] > ONE_Q30) ? ONE_Q30 : quo_r[QUOT_BITS];
    ang_prod = 61'(qclip) * 61'(QUARTER_PI_Q30);
    rad_prod = 61'({dv_r[QUOT_BITS], 14'd0}) * 61'(GAIN_Q30);
    ang_nxt  = neg_r[QUOT_BITS] ? -$signed({2'b00, ang_prod[60:30]})
                                :  $signed({2'b00, ang_prod[60:30]});
  end

  always_ff @(posedge clk) begin
    if (ld[S_MUL]) begin
      cor_r[0].x       <= $signed({2'b00, rad_prod[60:30]});
      cor_r[0].y       <= '0;
      cor_r[0].z       <= ang_nxt;
      cor_r[0].quarter <= qtr_r[QUOT_BITS];
    end
  end

  // ---------------- CORDIC rotation, one step per stage ----------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    cdch_cor_t cor_nxt;
    logic signed [32:0] dx, dy, da;

    always_comb begin
      dx = cor_r[i].y >>> i;
      dy = cor_r[i].x >>> i;
      da = $signed({3'b000, atan_q30(5'(i))});
      cor_nxt.quarter = cor_r[i].quarter;
      if (!cor_r[i].z[32]) begin
        cor_nxt.x = cor_r[i].x - dx;
        cor_nxt.y = cor_r[i].y + dy;
        cor_nxt.z = cor_r[i].z - da;
      end else begin
        cor_nxt.x = cor_r[i].x + dx;
        cor_nxt.y = cor_r[i].y - dy;
        cor_nxt.z = cor_r[i].z + da;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[S_MUL + 1 + i]) begin
        cor_r[i+1] <= cor_nxt;
      end
    end
  end

  // ---------------- quarter turn, rounding and saturation ----------------
  function automatic logic signed [15:0] to_out(input logic signed [32:0] v);
    logic signed [32:0] t;
    logic signed [17:0] r;
    t = v + 33'sd16384;
    r = 18'(t >>> (ANG_FRAC - OUT_FRAC_BITS));
    if (r < -18'sd32768) begin
      return -16'sd32768;
    end else if (r > 18'sd32767) begin
      return 16'sd32767;
    end
    return r[15:0];
  endfunction

  logic signed [32:0] cs, sn;
  logic signed [15:0] xo_r, yo_r;

  always_comb begin
    case (cor_r[CORDIC_STEPS].quarter)
      2'd0:    begin cs =  cor_r[CORDIC_STEPS].x; sn =  cor_r[CORDIC_STEPS].y; end
      2'd1:    begin cs = -cor_r[CORDIC_STEPS].y; sn =  cor_r[CORDIC_STEPS].x; end
      2'd2:    begin cs = -cor_r[CORDIC_STEPS].x; sn = -cor_r[CORDIC_STEPS].y; end
      default: begin cs =  cor_r[CORDIC_STEPS].y; sn = -cor_r[CORDIC_STEPS].x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[S_RND]) begin
      xo_r <= to_out(cs);
      yo_r <= to_out(sn);
    end
  end

  // ---------------- squared radius ----------------
  logic [31:0]        sq_r;
  logic signed [15:0] xs_r, ys_r;
  logic signed [31:0] xx, yy;

  always_comb begin
    xx = xo_r * xo_r;
    yy = yo_r * yo_r;
  end

  always_ff @(posedge clk) begin
    if (ld[S_SQ]) begin
      sq_r <= $unsigned(xx) + $unsigned(yy);
      xs_r <= xo_r;
      ys_r <= yo_r;
    end
  end

  // ---------------- integer square root, one result bit per stage ----------------
  localparam logic [31:0] ONE_SQ = 32'd1 << (2 * OUT_FRAC_BITS);

  logic [30:0]        rn_r [1:ROOT_STEPS];
  logic [30:0]        rr_r [1:ROOT_STEPS];
  logic signed [15:0] rx_r [1:ROOT_STEPS];
  logic signed [15:0] ry_r [1:ROOT_STEPS];

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [30:0] BIT = 31'd1 << (2 * (ROOT_STEPS - 1 - j));
    logic [30:0] n_in, r_in, trial;
    logic signed [15:0] x_in, y_in;

    always_comb begin
      if (j == 0) begin
        n_in = (sq_r >= ONE_SQ) ? '0 : 31'(ONE_SQ - sq_r);
        r_in = '0;
        x_in = xs_r;
        y_in = ys_r;
      end else begin
        n_in = rn_r[(j == 0) ? 1 : j];
        r_in = rr_r[(j == 0) ? 1 : j];
        x_in = rx_r[(j == 0) ? 1 : j];
        y_in = ry_r[(j == 0) ? 1 : j];
      end
      trial = r_in + BIT;
    end

    always_ff @(posedge clk) begin
      if (ld[S_SQ + 1 + j]) begin
        if (n_in >= trial) begin
          rn_r[j+1] <= n_in - trial;
          rr_r[j+1] <= (r_in >> 1) + BIT;
        end else begin
          rn_r[j+1] <= n_in;
          rr_r[j+1] <= r_in >> 1;
        end
        rx_r[j+1] <= x_in;
        ry_r[j+1] <= y_in;
      end
    end
  end

  assign out_tdata = {rr_r[ROOT_STEPS][15:0], ry_r[ROOT_STEPS], rx_r[ROOT_STEPS]};

  // ---------------- assertions ----------------
  a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] <= 16'd32768)
    else $error("height above 1.0");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused with an empty output stage");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[0] && dv_r[0] == '0) |-> rem_r[0] == '0)
    else $error("zero denominator outside the centre point");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[QUOT_BITS] && dv_r[QUOT_BITS] != '0) |-> quo_r[QUOT_BITS] <= ONE_Q30)
    else $error("wedge ratio above one");

endmodule
